[rtl/core/ledfx_pkg.sv]
// Shared types, codes, constants and the breath cosine table builder for the LED duty engine.
`default_nettype none

package ledfx_pkg;

    // Item kinds carried in the input tuser
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Printer activity codes
    localparam logic [1:0] ACT_IDLE     = 2'd0;
    localparam logic [1:0] ACT_PRINTING = 2'd1;
    localparam logic [1:0] ACT_PAUSED   = 2'd2;
    localparam logic [1:0] ACT_FAILED   = 2'd3;

    // Finish effect modes
    localparam logic [1:0] FMODE_OFF       = 2'd0;
    localparam logic [1:0] FMODE_BREATH    = 2'd1;
    localparam logic [1:0] FMODE_HEARTBEAT = 2'd2;

    // Configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 10;
    localparam logic [CFG_IW-1:0] REG_LED_ENABLE   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_BASE_BRIGHT  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FINISH_MODE  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FINISH_PEAK  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_FINISH_SECS  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_STROBE_EN    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_PAUSE_EN     = 3'd6;
    localparam logic [CFG_IW-1:0] REG_AUTO_ON      = 3'd7;

    // Field and state widths
    localparam int TDATA_W   = 8;
    localparam int DUTY_W    = 8;
    localparam int TIME_W    = 32;
    localparam int SINCE_W   = 8;
    localparam int ELAPSED_W = 20;
    localparam int SECONDS_W = 10;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Finish effect length limits
    localparam int MS_PER_S       = 1000;
    localparam int FINISH_SEC_MIN = 5;
    localparam int FINISH_SEC_MAX = 600;

    // Heartbeat segment edges in milliseconds
    localparam int HB_SEG1 = 150;
    localparam int HB_SEG2 = 300;
    localparam int HB_SEG3 = 450;
    localparam int HB_SEG4 = 600;

    // x / HB_SEG1 as (x * HB_RECIP) >> HB_RECIP_SHIFT, exact for x up to 255 * HB_SEG1
    localparam int HB_RECIP_SHIFT = 24;
    localparam int HB_RECIP       = ((1 << HB_RECIP_SHIFT) + HB_SEG1 - 1) / HB_SEG1;
    localparam int PEAK_K_W       = 25;

    // Breath cosine table
    localparam int COS_IW      = 10;
    localparam int COS_STEPS   = 1024;
    localparam int COS_HALF    = 512;
    localparam int COS_QUARTER = 256;
    localparam int COS_DW      = 16;
    localparam int COS_TERMS   = 10;

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] COS_DIV [COS_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

    typedef logic [COS_DW-1:0] t_cos_rom [COS_STEPS];

    // Pattern selection handed from the core to the duty datapath
    typedef struct packed {
        logic strobe;
        logic strobe_dark;
        logic finish;
        logic heartbeat;
        logic pause;
        logic auto_on;
        logic printing;
    } t_duty_sel;

    // cos(m*pi/512) in Q30, alternating series kept as two positive sums; elaboration only
    function automatic logic [63:0] cos_q30(input logic [63:0] m);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        int          n;
        theta = (m * PI_Q30) >> 9;
        x2    = (theta * theta) >> 30;
        term  = ONE_Q30;
        plus  = ONE_Q30;
        minus = '0;
        for (n = 1; n <= COS_TERMS; n++) begin
            term = ((term * x2) >> 30) / COS_DIV[n-1];
            if (n[0]) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        return (plus > minus) ? (plus - minus) : '0;
    endfunction

    // Raised cosine (1 - cos) / 2 in Q0.16 over one full period
    function automatic t_cos_rom breath_rom();
        t_cos_rom    rom;
        logic [63:0] idx;
        logic [63:0] raw;
        logic [63:0] c;
        logic [63:0] v;
        int          k;
        for (k = 0; k < COS_STEPS; k++) begin
            idx = (k <= COS_HALF) ? 64'(k) : 64'(COS_STEPS - k);
            if (idx <= 64'(COS_QUARTER)) begin
                c   = cos_q30(idx);
                raw = (c < ONE_Q30) ? (ONE_Q30 - c) : '0;
            end else begin
                raw = ONE_Q30 + cos_q30(64'(COS_HALF) - idx);
            end
            v = (raw + 64'd16384) >> 15;
            rom[k] = (v > 64'd65535) ? 16'hFFFF : v[COS_DW-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ledfx_breath.sv]
// Breath phase tracker: phase, table index and remainder held one millisecond ahead, with cosine ROM.
`default_nettype none

module ledfx_breath import ledfx_pkg::*; #(
    parameter int PERIOD_MS = 3000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_zero,
    input  logic              i_load,
    output logic [COS_DW-1:0] o_cos
);

    localparam int PW = $clog2(PERIOD_MS + 1);
    localparam logic [PW-1:0]     P_LAST = PW'(PERIOD_MS - 1);
    localparam logic [PW:0]       P_FULL = (PW+1)'(PERIOD_MS);
    localparam logic [COS_IW-1:0] Q_STEP = COS_IW'(COS_STEPS / PERIOD_MS);
    localparam logic [PW:0]       R_STEP = (PW+1)'(COS_STEPS % PERIOD_MS);
    localparam bit                UNIT   = (PERIOD_MS == 1);
    localparam logic [PW-1:0]     P_ONE  = UNIT ? '0 : PW'(1);
    localparam logic [COS_IW-1:0] Q_ONE  = UNIT ? '0 : Q_STEP;
    localparam logic [PW-1:0]     R_ONE  = UNIT ? '0 : R_STEP[PW-1:0];
    localparam t_cos_rom          COS_ROM = breath_rom();

    logic [PW-1:0]     r_p, n_p;
    logic [COS_IW-1:0] r_q, n_q;
    logic [PW-1:0]     r_r, n_r;
    logic [PW:0]       rem_sum;
    logic [PW:0]       rem_fold;
    logic              rem_wrap;
    logic [COS_DW-1:0] r_cos;

    // p*1024 = q*period + r, kept by adding the constant step each millisecond
    always_comb begin
        rem_sum  = {1'b0, r_r} + R_STEP;
        rem_fold = rem_sum - P_FULL;
        rem_wrap = (rem_sum >= P_FULL);
        n_p = r_p;
        n_q = r_q;
        n_r = r_r;
        if (!i_rst_n || i_load) begin
            n_p = P_ONE;
            n_q = Q_ONE;
            n_r = R_ONE;
        end else if (i_zero || (i_step && (r_p == P_LAST))) begin
            n_p = '0;
            n_q = '0;
            n_r = '0;
        end else if (i_step) begin
            n_p = r_p + PW'(1);
            n_q = r_q + Q_STEP + COS_IW'(rem_wrap);
            n_r = rem_wrap ? rem_fold[PW-1:0] : rem_sum[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_q <= n_q;
        r_r <= n_r;
    end

    // ROM read follows the next index, so the data matches the held phase
    always_ff @(posedge i_clk) begin
        r_cos <= COS_ROM[n_q];
    end

    assign o_cos = r_cos;

endmodule

`default_nettype wire

[rtl/core/ledfx_duty.sv]
// Duty datapath: strobe, heartbeat and breath patterns and their priority selection.
`default_nettype none

module ledfx_duty import ledfx_pkg::*; #(
    parameter int HEARTBEAT_PERIOD_MS = 1500
) (
    input  t_duty_sel                                   i_sel,
    input  logic [DUTY_W-1:0]                           i_base,
    input  logic [DUTY_W-1:0]                           i_fin_peak,
    input  logic [PEAK_K_W-1:0]                         i_fin_peak_k,
    input  logic [$clog2(HEARTBEAT_PERIOD_MS+1)-1:0]    i_hb_phase,
    input  logic [COS_DW-1:0]                           i_fin_cos,
    input  logic [COS_DW-1:0]                           i_pause_cos,
    output logic [DUTY_W-1:0]                           o_duty
);

    localparam int HW = $clog2(HEARTBEAT_PERIOD_MS + 1);
    localparam int HP = DUTY_W + PEAK_K_W;
    localparam int BP = COS_DW + 1 + DUTY_W;

    logic [HW-1:0]       hb_x;
    logic [HP-1:0]       hb_prod;
    logic [DUTY_W-1:0]   hb_duty;
    logic [COS_DW:0]     fin_lvl;
    logic [BP-1:0]       fin_prod;
    logic [COS_DW:0]     pause_lvl;
    logic [BP-1:0]       pause_prod;

    // Two beats of the heart: up, down, up, down, then silence
    always_comb begin
        if (i_hb_phase < HW'(HB_SEG1)) begin
            hb_x = i_hb_phase;
        end else if (i_hb_phase < HW'(HB_SEG2)) begin
            hb_x = HW'(HB_SEG2) - i_hb_phase;
        end else if (i_hb_phase < HW'(HB_SEG3)) begin
            hb_x = i_hb_phase - HW'(HB_SEG2);
        end else if (i_hb_phase < HW'(HB_SEG4)) begin
            hb_x = HW'(HB_SEG4) - i_hb_phase;
        end else begin
            hb_x = '0;
        end
    end

    assign hb_prod    = HP'(hb_x[DUTY_W-1:0]) * HP'(i_fin_peak_k);
    assign hb_duty    = hb_prod[HB_RECIP_SHIFT +: DUTY_W];

    assign fin_lvl    = {1'b0, i_fin_cos} + (COS_DW+1)'(1);
    assign fin_prod   = BP'(fin_lvl) * BP'(i_fin_peak);
    assign pause_lvl  = {1'b0, i_pause_cos} + (COS_DW+1)'(1);
    assign pause_prod = BP'(pause_lvl) * BP'(i_base);

    always_comb begin
        if (i_sel.strobe) begin
            o_duty = i_sel.strobe_dark ? '0 : i_base;
        end else if (i_sel.finish) begin
            o_duty = i_sel.heartbeat ? hb_duty : fin_prod[COS_DW +: DUTY_W];
        end else if (i_sel.pause) begin
            o_duty = pause_prod[COS_DW +: DUTY_W];
        end else if (i_sel.auto_on) begin
            o_duty = i_sel.printing ? i_base : '0;
        end else begin
            o_duty = i_base;
        end
    end

endmodule

`default_nettype wire

[rtl/core/led_effect_duty_engine_core.sv]
// LED effect duty engine top level: settings, time base, finish effect state and stream handshake.
`default_nettype none

// Channel   | Beat moves                         | Accepted when
// ----------+------------------------------------+------------------------------------
// cfg       | register index, write data         | i_cfg_valid (o_cfg_ready is high)
// s_axis    | tuser: kind, tdata: activity       | i_s_axis_tvalid && o_s_axis_tready
// m_axis    | tdata: duty, tuser: written, run   | o_m_axis_tvalid && i_m_axis_tready
//
// Every input beat is worked in the cycle it is accepted and its single result
// beat appears in the output register in the next cycle; one beat per cycle unless m_axis stalls.
// The output register alone parts the sides: s_axis is ready while the result
// slot is empty or being drained, so a stall on m_axis holds the input off.
// Reset (i_rst_n low, synchronous) restores all settings and clears time base,
// finish effect and the written-duty memory; no clearing pass follows.

module led_effect_duty_engine_core import ledfx_pkg::*; #(
    parameter int UPDATE_INTERVAL_MS  = 16,
    parameter int STROBE_HALF_MS      = 100,
    parameter int HEARTBEAT_PERIOD_MS = 1500,
    parameter int BREATH_PERIOD_MS    = 3000,
    parameter int PAUSE_PERIOD_MS     = 4000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data,
    // input items
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // [1:0] activity, [7:2] zero
    input  logic [1:0]         i_s_axis_tuser,   // [1:0] kind
    // results
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [7:0] duty
    output logic [1:0]         o_m_axis_tuser    // [0] duty_written, [1] finish_running
);

    localparam int SW = $clog2(STROBE_HALF_MS + 1);
    localparam int HW = $clog2(HEARTBEAT_PERIOD_MS + 1);
    localparam logic [SW-1:0]        S_LAST       = SW'(STROBE_HALF_MS - 1);
    localparam logic [HW-1:0]        H_LAST       = HW'(HEARTBEAT_PERIOD_MS - 1);
    localparam logic [SINCE_W-1:0]   UPD          = SINCE_W'(UPDATE_INTERVAL_MS);
    localparam logic [SINCE_W-1:0]   SINCE_MAX    = '1;
    localparam logic [TIME_W-1:0]    TIME_LAST    = '1;
    localparam logic [TIME_W-1:0]    TIME_PRELAST = {{(TIME_W-1){1'b1}}, 1'b0};
    localparam logic [ELAPSED_W-1:0] ELAPSED_PRE  = ELAPSED_MAX - ELAPSED_W'(1);
    localparam logic [PEAK_K_W-1:0]  PEAK_K_RST   = PEAK_K_W'(255 * HB_RECIP);

    // ---------------------------------------------------------------------
    // Settings
    // ---------------------------------------------------------------------
    logic                 r_led_enable;
    logic [DUTY_W-1:0]    r_base;
    logic [1:0]           r_fmode;
    logic [DUTY_W-1:0]    r_fpeak;
    logic [SECONDS_W-1:0] r_fsecs;
    logic                 r_strobe_en;
    logic                 r_pause_en;
    logic                 r_auto_on;
    logic                 cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_enable <= 1'b0;
            r_base       <= DUTY_W'(128);
            r_fmode      <= FMODE_OFF;
            r_fpeak      <= DUTY_W'(255);
            r_fsecs      <= SECONDS_W'(30);
            r_strobe_en  <= 1'b0;
            r_pause_en   <= 1'b0;
            r_auto_on    <= 1'b0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_LED_ENABLE:  r_led_enable <= i_cfg_data[0];
                REG_BASE_BRIGHT: r_base       <= i_cfg_data[DUTY_W-1:0];
                REG_FINISH_MODE: r_fmode      <= i_cfg_data[1:0];
                REG_FINISH_PEAK: r_fpeak      <= i_cfg_data[DUTY_W-1:0];
                REG_FINISH_SECS: r_fsecs      <= i_cfg_data[SECONDS_W-1:0];
                REG_STROBE_EN:   r_strobe_en  <= i_cfg_data[0];
                REG_PAUSE_EN:    r_pause_en   <= i_cfg_data[0];
                REG_AUTO_ON:     r_auto_on    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Engine state
    // ---------------------------------------------------------------------
    logic [TIME_W-1:0]    r_time,      n_time;
    logic [SINCE_W-1:0]   r_since,     n_since;
    logic                 r_active,    n_active;
    logic [ELAPSED_W-1:0] r_elapsed,   n_elapsed;
    logic [ELAPSED_W-1:0] r_len,       n_len;
    logic [1:0]           r_mode_held, n_mode_held;
    logic [DUTY_W-1:0]    r_peak_held, n_peak_held;
    logic [PEAK_K_W-1:0]  r_peak_k,    n_peak_k;
    logic [DUTY_W-1:0]    r_last,      n_last;
    logic                 r_known,     n_known;
    logic [SW-1:0]        r_scnt,      n_scnt;
    logic                 r_spar,      n_spar;
    logic [HW-1:0]        r_hb,        n_hb;
    logic                 written;

    // Input beat decode
    logic        s_accept;
    logic [1:0]  in_kind;
    logic [1:0]  in_act;
    logic        is_tick;
    logic        is_start;
    logic        start_ok;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_kind  = i_s_axis_tuser;
    assign in_act   = i_s_axis_tdata[1:0];
    assign is_tick  = s_accept && (in_kind == KIND_TICK);
    assign is_start = s_accept && (in_kind == KIND_START);
    assign start_ok = r_led_enable && ((r_fmode == FMODE_BREATH) || (r_fmode == FMODE_HEARTBEAT));

    // Values after one millisecond advance
    logic [SINCE_W-1:0]   since_inc;
    logic                 elapsed_run;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [SW-1:0]        scnt_next;
    logic                 spar_next;
    logic [HW-1:0]        hb_next;
    logic                 upd;
    logic                 timeout;
    logic                 known_eff;

    assign since_inc   = (r_since != SINCE_MAX) ? (r_since + SINCE_W'(1)) : r_since;
    assign elapsed_run = r_active && (r_elapsed != ELAPSED_MAX);
    assign elapsed_inc = elapsed_run ? (r_elapsed + ELAPSED_W'(1)) : r_elapsed;
    assign hb_next     = !elapsed_run    ? r_hb :
                         (r_hb == H_LAST) ? '0   : (r_hb + HW'(1));
    assign upd         = r_led_enable && (since_inc >= UPD);
    assign timeout     = r_active && (elapsed_inc >= r_len);
    assign known_eff   = r_known && !timeout;

    // Strobe half-period counter, restarted when the time base wraps
    always_comb begin
        if (r_time == TIME_LAST) begin
            scnt_next = '0;
            spar_next = 1'b0;
        end else if (r_scnt == S_LAST) begin
            scnt_next = '0;
            spar_next = !r_spar;
        end else begin
            scnt_next = r_scnt + SW'(1);
            spar_next = r_spar;
        end
    end

    // Finish effect length and heartbeat scale, taken at start
    logic [SECONDS_W-1:0] secs_clamped;
    logic [ELAPSED_W-1:0] len_start;
    logic [PEAK_K_W-1:0]  peak_k_start;

    always_comb begin
        if (r_fsecs < SECONDS_W'(FINISH_SEC_MIN)) begin
            secs_clamped = SECONDS_W'(FINISH_SEC_MIN);
        end else if (r_fsecs > SECONDS_W'(FINISH_SEC_MAX)) begin
            secs_clamped = SECONDS_W'(FINISH_SEC_MAX);
        end else begin
            secs_clamped = r_fsecs;
        end
    end

    assign len_start    = ELAPSED_W'(secs_clamped) * ELAPSED_W'(MS_PER_S);
    assign peak_k_start = PEAK_K_W'(r_fpeak) * PEAK_K_W'(HB_RECIP);

    // ---------------------------------------------------------------------
    // Breath phase trackers, each one millisecond ahead of its time base
    // ---------------------------------------------------------------------
    logic [COS_DW-1:0] pause_cos;
    logic [COS_DW-1:0] fin_cos;

    ledfx_breath #(
        .PERIOD_MS (PAUSE_PERIOD_MS)
    ) u_pause_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (is_tick),
        .i_zero  (is_tick && (r_time == TIME_PRELAST)),
        .i_load  (1'b0),
        .o_cos   (pause_cos)
    );

    ledfx_breath #(
        .PERIOD_MS (BREATH_PERIOD_MS)
    ) u_finish_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (is_tick && r_active && (r_elapsed != ELAPSED_MAX) &&
                  (r_elapsed != ELAPSED_PRE)),
        .i_zero  (1'b0),
        .i_load  (is_start && start_ok),
        .o_cos   (fin_cos)
    );

    // ---------------------------------------------------------------------
    // Duty selection
    // ---------------------------------------------------------------------
    t_duty_sel         sel;
    logic [DUTY_W-1:0] duty_calc;

    always_comb begin
        sel.strobe      = r_strobe_en && (in_act == ACT_FAILED);
        sel.strobe_dark = spar_next;
        sel.finish      = r_active && !timeout;
        sel.heartbeat   = (r_mode_held == FMODE_HEARTBEAT);
        sel.pause       = r_pause_en && (in_act == ACT_PAUSED);
        sel.auto_on     = r_auto_on;
        sel.printing    = (in_act == ACT_PRINTING);
    end

    ledfx_duty #(
        .HEARTBEAT_PERIOD_MS (HEARTBEAT_PERIOD_MS)
    ) u_duty (
        .i_sel        (sel),
        .i_base       (r_base),
        .i_fin_peak   (r_peak_held),
        .i_fin_peak_k (r_peak_k),
        .i_hb_phase   (hb_next),
        .i_fin_cos    (fin_cos),
        .i_pause_cos  (pause_cos),
        .o_duty       (duty_calc)
    );

    // ---------------------------------------------------------------------
    // Next state for one accepted beat
    // ---------------------------------------------------------------------
    always_comb begin
        n_time      = r_time;
        n_since     = r_since;
        n_active    = r_active;
        n_elapsed   = r_elapsed;
        n_len       = r_len;
        n_mode_held = r_mode_held;
        n_peak_held = r_peak_held;
        n_peak_k    = r_peak_k;
        n_last      = r_last;
        n_known     = r_known;
        n_scnt      = r_scnt;
        n_spar      = r_spar;
        n_hb        = r_hb;
        written     = 1'b0;

        if (s_accept) begin
            unique case (in_kind)
                KIND_TICK: begin
                    // advance the time base; update only every interval
                    n_time    = r_time + TIME_W'(1);
                    n_since   = since_inc;
                    n_elapsed = elapsed_inc;
                    n_scnt    = scnt_next;
                    n_spar    = spar_next;
                    n_hb      = hb_next;
                    if (upd) begin
                        n_since = '0;
                        if (timeout) begin
                            n_active = 1'b0;
                            n_known  = 1'b0;
                        end
                        if (!known_eff || (duty_calc != r_last)) begin
                            n_last  = duty_calc;
                            n_known = 1'b1;
                            written = 1'b1;
                        end
                    end
                end
                KIND_START: begin
                    // restart with fresh settings, also while running
                    if (start_ok) begin
                        n_mode_held = r_fmode;
                        n_peak_held = r_fpeak;
                        n_peak_k    = peak_k_start;
                        n_elapsed   = '0;
                        n_len       = len_start;
                        n_active    = 1'b1;
                        n_hb        = '0;
                    end
                end
                KIND_STOP: begin
                    // force a write at the next update
                    if (r_active) begin
                        n_active = 1'b0;
                        n_known  = 1'b0;
                    end
                end
                default: ;
            endcase

            // disabled: hold duty at zero and drop the written-duty memory
            if (!r_led_enable) begin
                n_last  = '0;
                n_known = 1'b0;
                written = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_since     <= '0;
            r_active    <= 1'b0;
            r_elapsed   <= '0;
            r_len       <= '0;
            r_mode_held <= FMODE_OFF;
            r_peak_held <= DUTY_W'(255);
            r_peak_k    <= PEAK_K_RST;
            r_last      <= '0;
            r_known     <= 1'b0;
            r_scnt      <= '0;
            r_spar      <= 1'b0;
            r_hb        <= '0;
        end else begin
            r_time      <= n_time;
            r_since     <= n_since;
            r_active    <= n_active;
            r_elapsed   <= n_elapsed;
            r_len       <= n_len;
            r_mode_held <= n_mode_held;
            r_peak_held <= n_peak_held;
            r_peak_k    <= n_peak_k;
            r_last      <= n_last;
            r_known     <= n_known;
            r_scnt      <= n_scnt;
            r_spar      <= n_spar;
            r_hb        <= n_hb;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    logic              r_m_valid;
    logic [DUTY_W-1:0] r_m_duty;
    logic              r_m_written;
    logic              r_m_running;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_duty    <= n_last;
            r_m_written <= written;
            r_m_running <= n_active;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_duty;
    assign o_m_axis_tuser  = {r_m_running, r_m_written};

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the LED duty engine: directed table, random settings phases, effect soaks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ledfx_pkg::*;

    // Engine timing, kept equal to the instance parameters below
    localparam int UPDATE_MS    = 16;
    localparam int STROBE_MS    = 100;
    localparam int HEARTBEAT_MS = 1500;
    localparam int BREATH_MS    = 3000;
    localparam int PAUSE_MS     = 4000;
    localparam int RAMP_MS      = 150;   // one heartbeat ramp
    localparam int SECS_MIN     = 5;
    localparam int SECS_MAX     = 600;
    localparam int MS_IN_S      = 1000;

    localparam logic [1:0] KIND_NONE   = 2'd3;   // unused kind code, changes nothing
    localparam logic [1:0] FMODE_SPARE = 2'd3;   // unused mode code, counts as off

    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 900;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned Q30_PI  = 64'd3373259426;

    typedef struct packed {
        logic [7:0] duty;
        logic       wr;
        logic       run;
    } t_duty_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic [CFG_IW-1:0]  reg_idx;
        logic [CFG_DW-1:0]  value;
        logic [1:0]         kind;
        logic [1:0]         act;
        logic [4:0]         rep;
        logic               pinned;
        logic [7:0]         pduty;
        logic               pwr;
        logic               prun;
    } t_dir_row;

    // Directed table: pinned rows carry their result, the rest go to the predictor
    localparam t_dir_row DIRECTED_ROWS [19] = '{
        // disabled after reset: time runs, duty held at zero
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_TICK,  ACT_IDLE,     5'd1, 1'b1, 8'd0, 1'b0, 1'b0},
        // start while disabled is dropped
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_START, ACT_PRINTING, 5'd1, 1'b1, 8'd0, 1'b0, 1'b0},
        // stop with nothing running is dropped
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_STOP,  ACT_PAUSED,   5'd1, 1'b1, 8'd0, 1'b0, 1'b0},
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_NONE,  ACT_FAILED,   5'd1, 1'b1, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_LED_ENABLE,  10'd1,   KIND_TICK, ACT_IDLE, 5'd0, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_BASE_BRIGHT, 10'd255, KIND_TICK, ACT_IDLE, 5'd0, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_FINISH_MODE, 10'(FMODE_SPARE), KIND_TICK, ACT_IDLE,
          5'd0, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_FINISH_PEAK, 10'd0,   KIND_TICK, ACT_IDLE, 5'd0, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_FINISH_SECS, 10'd0,   KIND_TICK, ACT_IDLE, 5'd0, 1'b0, 8'd0, 1'b0, 1'b0},
        // spare mode code: start is dropped
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_START, ACT_PRINTING, 5'd1, 1'b1, 8'd0, 1'b0, 1'b0},
        '{ROW_CFG,  REG_FINISH_MODE, 10'(FMODE_HEARTBEAT), KIND_TICK, ACT_IDLE,
          5'd0, 1'b0, 8'd0, 1'b0, 1'b0},
        // heartbeat starts, no update yet so duty stays zero
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_START, ACT_FAILED,   5'd1, 1'b1, 8'd0, 1'b0, 1'b1},
        // restart while running
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_START, ACT_PAUSED,   5'd1, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_STOP,  ACT_IDLE,     5'd1, 1'b1, 8'd0, 1'b0, 1'b0},
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_STOP,  ACT_IDLE,     5'd1, 1'b0, 8'd0, 1'b0, 1'b0},
        // run up to the first update, forced write of the base brightness
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_TICK,  ACT_IDLE,     5'd4, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_TICK,  ACT_PRINTING, 5'd4, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_TICK,  ACT_PAUSED,   5'd4, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ROW_ITEM, REG_LED_ENABLE, 10'd0, KIND_TICK,  ACT_FAILED,   5'd4, 1'b0, 8'd0, 1'b0, 1'b0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [TDATA_W-1:0] i_s_axis_tdata = '0;   // [1:0] activity, [7:2] zero
    logic [1:0]         i_s_axis_tuser = '0;   // [1:0] kind
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_axis_tdata;        // [7:0] duty
    logic [1:0]         o_m_axis_tuser;        // [0] duty written, [1] finish running

    // Pinned result travelling alongside the beat on the input side
    logic               item_pinned = 1'b0;
    t_duty_res          item_pinned_res = '0;

    // Engine settings and state as the predictor sees them
    logic               cfg_led_en;
    logic [7:0]         cfg_base;
    logic [1:0]         cfg_fmode;
    logic [7:0]         cfg_fpeak;
    logic [9:0]         cfg_fsecs;
    logic               cfg_strobe_en;
    logic               cfg_pause_en;
    logic               cfg_auto_on;
    logic [31:0]        ms_count;
    logic [7:0]         since_upd;
    logic               fx_on;
    logic [19:0]        fx_elapsed;
    logic [19:0]        fx_len;
    logic [1:0]         fx_mode;
    logic [7:0]         fx_peak;
    logic [7:0]         duty_q;
    logic               duty_known;
    logic [15:0]        raised_cos [1024];

    t_duty_res          duty_due_q [$];
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 rand_items = 0;
    int                 phase_no = 0;

    led_effect_duty_engine_core #(
        .UPDATE_INTERVAL_MS  (UPDATE_MS),
        .STROBE_HALF_MS      (STROBE_MS),
        .HEARTBEAT_PERIOD_MS (HEARTBEAT_MS),
        .BREATH_PERIOD_MS    (BREATH_MS),
        .PAUSE_PERIOD_MS     (PAUSE_MS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // cos(m * pi / 512) in Q30 from the alternating series, kept as two positive sums
    function automatic longint unsigned cos_q30_series(input int unsigned m);
        longint unsigned th;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned dv;
        int              n;
        th   = (longint'(m) * Q30_PI) / 512;
        x2   = (th * th) >> 30;
        term = Q30_ONE;
        pos  = Q30_ONE;
        neg  = 64'd0;
        for (n = 1; n <= 10; n++) begin
            dv   = 64'((2 * n - 1) * (2 * n));
            term = ((term * x2) >> 30) / dv;
            if (n % 2 == 1) begin
                neg += term;
            end else begin
                pos += term;
            end
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    task automatic build_raised_cos();
        int unsigned     k;
        int unsigned     idx;
        longint unsigned c;
        longint unsigned raw;
        longint unsigned v;
        for (k = 0; k < 1024; k++) begin
            idx = (k <= 512) ? k : 1024 - k;
            if (idx <= 256) begin
                c   = cos_q30_series(idx);
                raw = (c < Q30_ONE) ? Q30_ONE - c : 64'd0;
            end else begin
                raw = Q30_ONE + cos_q30_series(512 - idx);
            end
            v = (raw + 64'd16384) >> 15;
            raised_cos[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
    endtask

    task automatic predictor_reset();
        cfg_led_en    = 1'b0;
        cfg_base      = 8'd128;
        cfg_fmode     = FMODE_OFF;
        cfg_fpeak     = 8'd255;
        cfg_fsecs     = 10'd30;
        cfg_strobe_en = 1'b0;
        cfg_pause_en  = 1'b0;
        cfg_auto_on   = 1'b0;
        ms_count      = '0;
        since_upd     = '0;
        fx_on         = 1'b0;
        fx_elapsed    = '0;
        fx_len        = '0;
        fx_mode       = FMODE_OFF;
        fx_peak       = 8'd255;
        duty_q        = '0;
        duty_known    = 1'b0;
    endtask

    function automatic logic [7:0] breath_level(input int unsigned ph, input int unsigned period,
                                                input logic [7:0] peak);
        int unsigned p;
        int unsigned w;
        p = ph % period;
        w = (int'(raised_cos[(p * 1024) / period]) + 1) * peak;
        return w[23:16];
    endfunction

    function automatic logic [7:0] heartbeat_level(input int unsigned ph, input logic [7:0] peak);
        int unsigned p;
        int unsigned lvl;
        p = ph % HEARTBEAT_MS;
        if (p < RAMP_MS)
            lvl = (p * peak) / RAMP_MS;
        else if (p < 2 * RAMP_MS)
            lvl = ((2 * RAMP_MS - p) * peak) / RAMP_MS;
        else if (p < 3 * RAMP_MS)
            lvl = ((p - 2 * RAMP_MS) * peak) / RAMP_MS;
        else if (p < 4 * RAMP_MS)
            lvl = ((4 * RAMP_MS - p) * peak) / RAMP_MS;
        else
            lvl = 0;
        return lvl[7:0];
    endfunction

    // Pattern by priority: strobe, finish effect, pause breath, auto-on, base
    function automatic logic [7:0] pattern_duty(input logic [1:0] act);
        if (cfg_strobe_en && act == ACT_FAILED)
            return ((ms_count / STROBE_MS) % 2 == 1) ? 8'd0 : cfg_base;
        if (fx_on) begin
            if (fx_mode == FMODE_HEARTBEAT)
                return heartbeat_level(fx_elapsed, fx_peak);
            return breath_level(fx_elapsed, BREATH_MS, fx_peak);
        end
        if (cfg_pause_en && act == ACT_PAUSED)
            return breath_level(ms_count, PAUSE_MS, cfg_base);
        if (cfg_auto_on)
            return (act == ACT_PRINTING) ? cfg_base : 8'd0;
        return cfg_base;
    endfunction

    task automatic advance_duty_engine(input logic [1:0] kind, input logic [1:0] act,
                                       output t_duty_res res);
        logic        wr;
        logic [7:0]  d;
        int unsigned secs;
        wr = 1'b0;
        case (kind)
            KIND_TICK: begin
                ms_count = ms_count + 32'd1;
                if (since_upd != 8'hFF) since_upd = since_upd + 8'd1;
                if (fx_on && fx_elapsed != ELAPSED_MAX) fx_elapsed = fx_elapsed + 20'd1;
                if (cfg_led_en && since_upd >= UPDATE_MS) begin
                    since_upd = '0;
                    // timeout is only looked at on update ticks
                    if (fx_on && fx_elapsed >= fx_len) begin
                        fx_on      = 1'b0;
                        duty_known = 1'b0;
                    end
                    d = pattern_duty(act);
                    if (!duty_known || d != duty_q) begin
                        duty_q     = d;
                        duty_known = 1'b1;
                        wr         = 1'b1;
                    end
                end
            end
            KIND_START: begin
                if (cfg_led_en && (cfg_fmode == FMODE_BREATH || cfg_fmode == FMODE_HEARTBEAT)) begin
                    secs = 32'(cfg_fsecs);
                    if (secs < SECS_MIN) secs = SECS_MIN;
                    if (secs > SECS_MAX) secs = SECS_MAX;
                    fx_mode    = cfg_fmode;
                    fx_peak    = cfg_fpeak;
                    fx_elapsed = '0;
                    fx_len     = 20'(secs * MS_IN_S);
                    fx_on      = 1'b1;
                end
            end
            KIND_STOP: begin
                if (fx_on) begin
                    fx_on      = 1'b0;
                    duty_known = 1'b0;
                end
            end
            default: ;
        endcase
        if (!cfg_led_en) begin
            duty_q     = '0;
            duty_known = 1'b0;
            wr         = 1'b0;
        end
        res.duty = duty_q;
        res.wr   = wr;
        res.run  = fx_on;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned due);
        if (mismatches < 40)
            $display("%0t: %s mismatch, got %0d, wanted %0d", $realtime, what, got, due);
        mismatches++;
    endtask

    // Receiver: stall at the rate of the current idling regime
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check result beats against the oldest due result, then predict the accepted input beat
    always @(posedge i_clk) begin : beat_monitor
        t_duty_res got;
        t_duty_res due;
        t_duty_res nxt;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.duty = o_m_axis_tdata[7:0];
                got.wr   = o_m_axis_tuser[0];
                got.run  = o_m_axis_tuser[1];
                if (duty_due_q.size() == 0) begin
                    report_mismatch("unrequested result beat, duty", got.duty, 0);
                end else begin
                    due = duty_due_q.pop_front();
                    if (got.duty != due.duty) report_mismatch("duty", got.duty, due.duty);
                    if (got.wr != due.wr) report_mismatch("duty_written", got.wr, due.wr);
                    if (got.run != due.run) report_mismatch("finish_running", got.run, due.run);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                advance_duty_engine(i_s_axis_tuser, i_s_axis_tdata[1:0], nxt);
                duty_due_q.push_back(item_pinned ? item_pinned_res : nxt);
            end
        end
    end

    task automatic set_regime(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
    endtask

    // Present one beat, hold it until taken, then maybe leave a gap
    task automatic send_item(input logic [1:0] kind, input logic [1:0] act,
                             input logic pinned, input t_duty_res pres);
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {6'd0, act};
        i_s_axis_tvalid <= 1'b1;
        item_pinned     <= pinned;
        item_pinned_res <= pres;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold the input off until every due result has come back, then settle
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (duty_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Valid is left high so writes can go back to back; the caller drops it
    task automatic reg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LED_ENABLE:  cfg_led_en    = val[0];
            REG_BASE_BRIGHT: cfg_base      = val[7:0];
            REG_FINISH_MODE: cfg_fmode     = val[1:0];
            REG_FINISH_PEAK: cfg_fpeak     = val[7:0];
            REG_FINISH_SECS: cfg_fsecs     = val[9:0];
            REG_STROBE_EN:   cfg_strobe_en = val[0];
            REG_PAUSE_EN:    cfg_pause_en  = val[0];
            REG_AUTO_ON:     cfg_auto_on   = val[0];
            default: ;
        endcase
    endtask

    task automatic run_directed();
        logic cfg_open;
        cfg_open = 1'b0;
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].op == ROW_CFG) begin
                if (!cfg_open) wait_drained();
                reg_write(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) i_cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                repeat (DIRECTED_ROWS[i].rep)
                    send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].pinned,
                              t_duty_res'{DIRECTED_ROWS[i].pduty, DIRECTED_ROWS[i].pwr,
                                          DIRECTED_ROWS[i].prun});
            end
        end
    endtask

    function automatic logic [CFG_DW-1:0] pick_value(input int unsigned top);
        case ($urandom_range(3))
            0:       return '0;
            1:       return top[CFG_DW-1:0];
            default: return CFG_DW'($urandom_range(top));
        endcase
    endfunction

    // Settings for one random phase: all high first, then all low, then mixed
    task automatic random_settings();
        logic hi;
        if (phase_no < 2) begin
            hi = (phase_no == 0);
            reg_write(REG_LED_ENABLE,  hi ? 10'd1 : 10'd0);
            reg_write(REG_BASE_BRIGHT, hi ? 10'd255 : 10'd0);
            reg_write(REG_FINISH_MODE, hi ? 10'(FMODE_SPARE) : 10'(FMODE_OFF));
            reg_write(REG_FINISH_PEAK, hi ? 10'd255 : 10'd0);
            reg_write(REG_FINISH_SECS, hi ? 10'd1023 : 10'd0);
            reg_write(REG_STROBE_EN,   hi ? 10'd1 : 10'd0);
            reg_write(REG_PAUSE_EN,    hi ? 10'd1 : 10'd0);
            reg_write(REG_AUTO_ON,     hi ? 10'd1 : 10'd0);
        end else begin
            reg_write(REG_LED_ENABLE,  ($urandom_range(9) != 0) ? 10'd1 : 10'd0);
            reg_write(REG_BASE_BRIGHT, pick_value(255));
            // favour the two live modes
            reg_write(REG_FINISH_MODE, ($urandom_range(3) == 0) ? pick_value(3)
                                       : 10'($urandom_range(2, 1)));
            reg_write(REG_FINISH_PEAK, pick_value(255));
            reg_write(REG_FINISH_SECS, pick_value(1023));
            reg_write(REG_STROBE_EN,   pick_value(1));
            reg_write(REG_PAUSE_EN,    pick_value(1));
            reg_write(REG_AUTO_ON,     pick_value(1));
        end
        i_cfg_valid <= 1'b0;
        phase_no++;
    endtask

    // Mostly ticks with a sticky activity; starts, stops and spare kinds now and then
    task automatic run_random(input int limit);
        int          n;
        int unsigned r;
        logic [1:0]  kind;
        logic [1:0]  act;
        act = ACT_IDLE;
        while (rand_items < limit) begin
            wait_drained();
            random_settings();
            n = $urandom_range(260, 80);
            repeat (n) begin
                if ($urandom_range(99) < 4) act = 2'($urandom_range(3));
                r = $urandom_range(999);
                if (r < 15)      kind = KIND_START;
                else if (r < 27) kind = KIND_STOP;
                else if (r < 32) kind = KIND_NONE;
                else             kind = KIND_TICK;
                send_item(kind, act, 1'b0, '0);
                if (kind != KIND_NONE) rand_items++;
            end
        end
    endtask

    // Let one finish effect play out over many ticks
    task automatic finish_soak(input logic [1:0] mode, input logic [CFG_DW-1:0] secs,
                               input int ticks);
        logic [1:0] act;
        act = ACT_PRINTING;
        wait_drained();
        reg_write(REG_LED_ENABLE,  10'd1);
        reg_write(REG_FINISH_MODE, 10'(mode));
        reg_write(REG_FINISH_PEAK, 10'($urandom_range(255, 160)));
        reg_write(REG_FINISH_SECS, secs);
        reg_write(REG_STROBE_EN,   10'd1);
        reg_write(REG_PAUSE_EN,    10'd1);
        reg_write(REG_AUTO_ON,     10'($urandom_range(1)));
        i_cfg_valid <= 1'b0;
        send_item(KIND_START, act, 1'b0, '0);
        repeat (ticks) begin
            if ($urandom_range(999) < 5) act = 2'($urandom_range(3));
            send_item(KIND_TICK, act, 1'b0, '0);
        end
        send_item(KIND_STOP, act, 1'b0, '0);
    endtask

    initial begin
        build_raised_cos();
        predictor_reset();
        set_regime(15, 64);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        // rising breath over its first few hundred milliseconds (seconds clamped up)
        finish_soak(FMODE_BREATH, 10'd0, 300);
        run_random(RANDOM_ITEMS / 3);

        set_regime(64, 15);
        run_random(2 * RANDOM_ITEMS / 3);
        // every heartbeat ramp and the silent tail
        finish_soak(FMODE_HEARTBEAT, 10'd5, 640);

        set_regime(0, 0);
        run_random(RANDOM_ITEMS);

        wait_drained();
        if (duty_due_q.size() != 0) report_mismatch("results still due", duty_due_q.size(), 0);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/ledfx_pkg.sv
rtl/core/ledfx_breath.sv
rtl/core/ledfx_duty.sv
rtl/core/led_effect_duty_engine_core.sv
bench/tb_top.sv
